### rtl/ffsa_pkg.sv
// Package for the first-fit segment allocator: item structs, segment entry,
// status and opcode codes, controller states and reset constants.
// No dependencies; the top level and both simulation files import it.
package ffsa_pkg;

  localparam int unsigned MAX_SEGMENTS    = 16;
  localparam int unsigned DATA_W          = 32;
  localparam logic [31:0] POOL_SIZE_RESET = 32'd16777216;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_OVER_TOTAL   = 3'd1,
    ST_NO_FIT       = 3'd2,
    ST_FULL         = 3'd3,
    ST_FREED_LARGER = 3'd4,
    ST_BAD_OFFSET   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_SPLIT_LO,
    S_SPLIT_HI,
    S_LARGEST,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                opcode;
    logic [DATA_W-1:0]  request_size;
    logic [DATA_W-1:0]  block_offset;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  result_offset;
    logic [DATA_W-1:0]  free_total;
    logic [DATA_W-1:0]  largest_free;
  } out_item_t;

  // One row of the segment table.
  typedef struct packed {
    logic               used;
    logic [DATA_W-1:0]  size;
  } seg_t;

endpackage

### rtl/ffsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module ffsa_ram #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/first_fit_segment_allocator.sv
// Top level of the first-fit segment allocator: controller and registers
// around one segment table RAM. Depends on ffsa_pkg and ffsa_ram.
//
//   Channel  Direction  Handshake               Payload
//   -------  ---------  ----------------------  ----------------------------
//   in       input      in_valid_i / in_ready_o  in_item_i  (in_item_t)
//   out      output     out_valid_o/out_ready_i  out_item_o (out_item_t)
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_data_i (pool_size)
//
// An item settled before the table walk (zero size or more than the free
// total) goes from acceptance straight to the largest-free pass over the
// table and then loads the output register. The longest item splits a
// segment: acceptance, a first-fit walk and shift, the two split writes,
// a largest-free pass over the grown table and the load of the output
// register. All of it is set by the single read port and single write
// port of the segment table RAM.
// After reset and after every pool_size write the block writes the first
// table row before it accepts an item.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its result waits in the final state until the old one is taken.
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int unsigned MaxSegments = MAX_SEGMENTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,

  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DATA_W-1:0] cfg_data_i
);

  // Table rows are indexed with IdxW bits; the segment count can reach
  // MaxSegments itself and so needs CntW bits.
  localparam int unsigned IdxW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam int unsigned SegW = $bits(seg_t);

  // Control state.
  state_e            state_q, state_d;
  logic              init_q, init_d;
  logic [DATA_W-1:0] pool_q, pool_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [DATA_W-1:0] free_q, free_d;
  logic              out_valid_q, out_valid_d;
  logic              rv_q, rv_d;
  logic [CntW-1:0]   i_q, i_d;
  logic [CntW-1:0]   sh_left_q, sh_left_d;

  // Per-item working registers.
  logic [IdxW-1:0]   k_q, k_d;
  logic [IdxW-1:0]   hit_q, hit_d;
  logic [IdxW-1:0]   s_q, s_d;
  logic [DATA_W-1:0] pos_q, pos_d;
  logic [DATA_W-1:0] best_q, best_d;
  op_e               op_q, op_d;
  logic [DATA_W-1:0] req_q, req_d;
  logic [DATA_W-1:0] off_q, off_d;
  logic [DATA_W-1:0] hsize_q, hsize_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] roff_q, roff_d;
  out_item_t         out_q, out_d;

  // Segment table RAM ports.
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [SegW-1:0]   ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_raddr;
  logic [SegW-1:0]   ram_rdata;

  seg_t              seg;
  logic              last;
  logic              in_ready;

  ffsa_ram #(
    .Width (SegW),
    .Depth (MaxSegments)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign seg  = seg_t'(ram_rdata);
  // The row returned by the RAM now is the last one of the table.
  assign last = (CntW'(k_q) == (count_q - CntW'(1)));

  // No item is taken while the first row is being written or while a
  // pool_size write arrives.
  assign in_ready    = (state_q == S_IDLE) && !init_q && !cfg_valid_i;
  assign in_ready_o  = in_ready;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    pool_d      = pool_q;
    count_d     = count_q;
    free_d      = free_q;
    out_valid_d = out_valid_q;
    rv_d        = 1'b0;
    i_d         = i_q;
    sh_left_d   = sh_left_q;
    k_d         = k_q;
    hit_d       = hit_q;
    s_d         = s_q;
    pos_d       = pos_q;
    best_d      = best_q;
    op_d        = op_q;
    req_d       = req_q;
    off_d       = off_q;
    hsize_d     = hsize_q;
    status_d    = status_q;
    roff_d      = roff_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (init_q) begin
          // Rebuild the table as one free segment covering the pool.
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = {1'b0, pool_q};
          count_d   = CntW'(1);
          free_d    = pool_q;
          init_d    = 1'b0;
        end else if (in_valid_i && in_ready) begin
          op_d     = in_item_i.opcode;
          req_d    = in_item_i.request_size;
          off_d    = in_item_i.block_offset;
          i_d      = '0;
          pos_d    = '0;
          best_d   = '0;
          roff_d   = '0;
          status_d = ST_OK;
          if (in_item_i.opcode == OP_FREE) begin
            state_d = S_SCAN;
          end else if (in_item_i.request_size > free_q) begin
            status_d = ST_OVER_TOTAL;
            state_d  = S_LARGEST;
          end else if (in_item_i.request_size == '0) begin
            state_d = S_LARGEST;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Reads are issued back to back; the row read in the previous cycle
        // is examined now, tagged by k_q.
        if (i_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = i_q[IdxW-1:0];
          k_d       = i_q[IdxW-1:0];
          i_d       = i_q + CntW'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          if (op_q == OP_ALLOC) begin
            if (!seg.used && (seg.size >= req_q)) begin
              hit_d   = k_q;
              hsize_d = seg.size;
              rv_d    = 1'b0;
              i_d     = '0;
              if (seg.size == req_q) begin
                // Exact fit: just mark the row used.
                ram_we    = 1'b1;
                ram_waddr = k_q;
                ram_wdata = {1'b1, req_q};
                free_d    = free_q - req_q;
                roff_d    = pos_q;
                state_d   = S_LARGEST;
              end else if (count_q >= CntW'(MaxSegments)) begin
                status_d = ST_FULL;
                state_d  = S_LARGEST;
              end else begin
                // Open a gap after the hit row, moving the tail up by one.
                s_d       = IdxW'(count_q - CntW'(1));
                sh_left_d = count_q - CntW'(k_q) - CntW'(1);
                state_d   = S_SHIFT;
              end
            end else begin
              pos_d = pos_q + seg.size;
              if (last) begin
                status_d = ST_NO_FIT;
                rv_d     = 1'b0;
                i_d      = '0;
                state_d  = S_LARGEST;
              end
            end
          end else begin
            if (pos_q == off_q) begin
              rv_d    = 1'b0;
              i_d     = '0;
              state_d = S_LARGEST;
              if (!seg.used) begin
                status_d = ST_BAD_OFFSET;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = k_q;
                ram_wdata = {1'b0, seg.size};
                free_d    = free_q + seg.size;
                status_d  = (req_q > seg.size) ? ST_FREED_LARGER : ST_OK;
              end
            end else if ((pos_q > off_q) || last) begin
              status_d = ST_BAD_OFFSET;
              rv_d     = 1'b0;
              i_d      = '0;
              state_d  = S_LARGEST;
            end else begin
              pos_d = pos_q + seg.size;
            end
          end
        end
      end

      S_SHIFT: begin
        // Read row s, write it to row s + 1 in the following cycle, from the top down.
        if (sh_left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = s_q;
          k_d       = s_q;
          s_d       = s_q - IdxW'(1);
          sh_left_d = sh_left_q - CntW'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = k_q + IdxW'(1);
          ram_wdata = ram_rdata;
        end
        if ((sh_left_q == '0) && !rv_q) begin
          state_d = S_SPLIT_LO;
        end
      end

      S_SPLIT_LO: begin
        ram_we    = 1'b1;
        ram_waddr = hit_q + IdxW'(1);
        ram_wdata = {1'b0, hsize_q - req_q};
        state_d   = S_SPLIT_HI;
      end

      S_SPLIT_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hit_q;
        ram_wdata = {1'b1, req_q};
        count_d   = count_q + CntW'(1);
        free_d    = free_q - req_q;
        roff_d    = pos_q;
        i_d       = '0;
        state_d   = S_LARGEST;
      end

      S_LARGEST: begin
        if (i_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = i_q[IdxW-1:0];
          k_d       = i_q[IdxW-1:0];
          i_d       = i_q + CntW'(1);
          rv_d      = 1'b1;
        end
        if (rv_q) begin
          if (!seg.used && (seg.size > best_q)) begin
            best_d = seg.size;
          end
          if (last) begin
            rv_d    = 1'b0;
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status        = status_q;
          out_d.result_offset = roff_q;
          out_d.free_total    = free_q;
          out_d.largest_free  = best_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A pool_size write resets the table on the next idle cycle.
    if (cfg_valid_i && cfg_ready_o) begin
      pool_d = cfg_data_i;
      init_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      init_q      <= 1'b1;
      pool_q      <= POOL_SIZE_RESET;
      count_q     <= CntW'(1);
      free_q      <= POOL_SIZE_RESET;
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      i_q         <= '0;
      sh_left_q   <= '0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      pool_q      <= pool_d;
      count_q     <= count_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      rv_q        <= rv_d;
      i_q         <= i_d;
      sh_left_q   <= sh_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    hit_q    <= hit_d;
    s_q      <= s_d;
    pos_q    <= pos_d;
    best_q   <= best_d;
    op_q     <= op_d;
    req_q    <= req_d;
    off_q    <= off_d;
    hsize_q  <= hsize_d;
    status_q <= status_d;
    roff_q   <= roff_d;
    out_q    <= out_d;
  end

endmodule

### sim/alloc_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the first-fit segment allocator: its own segment table,
// the results that table predicts, and the field-by-field result check.
// Depends on ffsa_pkg for the item structs, the status codes and the table size.
package alloc_check_pkg;
  import ffsa_pkg::*;

  class alloc_scoreboard;
    logic [31:0] pool_bytes;
    logic [31:0] seg_bytes [MAX_SEGMENTS];
    bit          seg_taken [MAX_SEGMENTS];
    int unsigned seg_count;
    logic [31:0] free_bytes;
    out_item_t   pending_replies [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      set_pool(POOL_SIZE_RESET);
    endfunction

    // A pool write starts over with one free segment covering the whole pool.
    function void set_pool(logic [31:0] bytes);
      pool_bytes = bytes;
      foreach (seg_bytes[k]) begin
        seg_bytes[k] = '0;
        seg_taken[k] = 1'b0;
      end
      seg_bytes[0] = bytes;
      seg_count    = 1;
      free_bytes   = bytes;
    endfunction

    function logic [31:0] seg_start(int unsigned idx);
      logic [63:0] pos;
      pos = '0;
      for (int unsigned j = 0; j < idx; j++) pos += seg_bytes[j];
      return pos[31:0];
    endfunction

    function status_e alloc_first_fit(logic [31:0] want, output logic [31:0] where);
      logic [63:0] pos;
      pos   = '0;
      where = '0;
      if (want > free_bytes) return ST_OVER_TOTAL;
      if (want == 0) return ST_OK;
      for (int unsigned k = 0; k < seg_count; k++) begin
        if (seg_taken[k] || seg_bytes[k] < want) begin
          pos += seg_bytes[k];
          continue;
        end
        // Only the first fitting segment is tried, even if the table is full.
        if (seg_bytes[k] != want) begin
          if (seg_count >= MAX_SEGMENTS) return ST_FULL;
          for (int unsigned j = seg_count; j > k + 1; j--) begin
            seg_bytes[j] = seg_bytes[j-1];
            seg_taken[j] = seg_taken[j-1];
          end
          seg_bytes[k+1] = seg_bytes[k] - want;
          seg_taken[k+1] = 1'b0;
          seg_bytes[k]   = want;
          seg_count++;
        end
        seg_taken[k] = 1'b1;
        free_bytes  -= want;
        where        = pos[31:0];
        return ST_OK;
      end
      return ST_NO_FIT;
    endfunction

    function status_e release_segment(logic [31:0] claim, logic [31:0] at);
      logic [63:0] pos;
      pos = '0;
      for (int unsigned k = 0; k < seg_count; k++) begin
        if (pos == {32'd0, at}) begin
          if (!seg_taken[k]) return ST_BAD_OFFSET;
          seg_taken[k] = 1'b0;
          free_bytes  += seg_bytes[k];
          if (claim > seg_bytes[k]) return ST_FREED_LARGER;
          return ST_OK;
        end
        if (pos > {32'd0, at}) break;
        pos += seg_bytes[k];
      end
      return ST_BAD_OFFSET;
    endfunction

    function logic [31:0] largest_hole();
      logic [31:0] best;
      best = '0;
      for (int unsigned k = 0; k < seg_count; k++)
        if (!seg_taken[k] && seg_bytes[k] > best) best = seg_bytes[k];
      return best;
    endfunction

    function void note_request(in_item_t req);
      out_item_t   exp;
      logic [31:0] where;
      where = '0;
      if (req.opcode == OP_ALLOC) exp.status = alloc_first_fit(req.request_size, where);
      else exp.status = release_segment(req.request_size, req.block_offset);
      exp.result_offset = where;
      exp.free_total    = free_bytes;
      exp.largest_free  = largest_hole();
      pending_replies.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_replies.size() == 0) begin
        $display("%0t: result with none expected, actual status %0d offset %0h",
                 $time, got.status, got.result_offset);
        mismatches++;
        return;
      end
      exp = pending_replies.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
        mismatches++;
      end
      if (got.result_offset !== exp.result_offset) begin
        $display("%0t: result_offset expected %0h actual %0h",
                 $time, exp.result_offset, got.result_offset);
        mismatches++;
      end
      if (got.free_total !== exp.free_total) begin
        $display("%0t: free_total expected %0h actual %0h",
                 $time, exp.free_total, got.free_total);
        mismatches++;
      end
      if (got.largest_free !== exp.largest_free) begin
        $display("%0t: largest_free expected %0h actual %0h",
                 $time, exp.largest_free, got.largest_free);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the first-fit segment allocator: directed and random
// requests over several pool sizes, checked against alloc_check_pkg.
// Depends on ffsa_pkg, alloc_check_pkg and the allocator RTL.
module tb;
  import ffsa_pkg::*;
  import alloc_check_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_data;

  alloc_scoreboard   sb;
  int unsigned       items_sent;
  int unsigned       results_seen;

  first_fit_segment_allocator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // This timeout lies far beyond the slowest correct run and only catches a
  // hung handshake.
  initial begin
    #500000;
    $display("Regression FAIL");
    $finish;
  end

  // Waits until the scoreboard holds no outstanding result. Called and
  // returning at a falling edge.
  task automatic wait_drained();
    while (sb.pending_replies.size() != 0) @(negedge clk);
  endtask

  // Offers one item and returns at the falling edge after it is accepted.
  // The sender idles in two of every three stretches of 50 items and runs
  // back to back in the third, so gaps land on every phase of the block.
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = (((items_sent / 50) % 3) != 0) ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    // The prediction is updated here, before the next item is drawn, so the
    // random generator always sees the table as the block will hold it.
    sb.note_request(item);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_alloc(input logic [31:0] bytes);
    in_item_t item;
    item.opcode       = OP_ALLOC;
    item.request_size = bytes;
    item.block_offset = '0;
    send_item(item);
  endtask

  task automatic send_free(input logic [31:0] at, input logic [31:0] claim);
    in_item_t item;
    item.opcode       = OP_FREE;
    item.request_size = claim;
    item.block_offset = at;
    send_item(item);
  endtask

  // The pool register is only written with the block idle: every result has
  // come back, then a further margin passes before the write is offered.
  task automatic write_pool(input logic [31:0] bytes);
    in_valid = 1'b0;
    wait_drained();
    repeat (64) @(negedge clk);
    cfg_data  = bytes;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_pool(bytes);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Draws one request from the current predicted table. About half are
  // allocations: mostly small chunks, some exact fits of a free segment, a
  // few of size zero and a few of any 32-bit size. The rest are frees,
  // mostly at the start of a used segment with a matching, larger or
  // smaller claimed size, and otherwise at a misaligned or random offset.
  function automatic in_item_t make_request(input logic [31:0] chunk);
    in_item_t    item;
    int unsigned pick;
    int unsigned k;
    logic [31:0] sz;
    item.opcode       = OP_ALLOC;
    item.request_size = $urandom_range(1, chunk);
    item.block_offset = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if (pick < 3) begin
        item.request_size = '0;
      end else if (pick < 12) begin
        k = $urandom_range(0, sb.seg_count - 1);
        if (!sb.seg_taken[k] && sb.seg_bytes[k] != 0) item.request_size = sb.seg_bytes[k];
      end else if (pick < 17) begin
        item.request_size = $urandom();
      end
    end else begin
      item.opcode = OP_FREE;
      k = $urandom_range(0, sb.seg_count - 1);
      for (int t = 0; t < 4 && !sb.seg_taken[k]; t++) k = $urandom_range(0, sb.seg_count - 1);
      sz                = sb.seg_bytes[k];
      item.request_size = sz;
      item.block_offset = sb.seg_start(k);
      if (pick >= 90) item.block_offset = $urandom();
      else if (pick >= 85) item.block_offset = item.block_offset + 1;
      if ($urandom_range(0, 3) == 0) begin
        item.request_size = (sz == '1) ? sz : $urandom_range(sz + 1, 32'hFFFF_FFFF);
      end else if ($urandom_range(0, 3) == 0) begin
        item.request_size = $urandom_range(0, sz);
      end
    end
    return item;
  endfunction

  // One random phase at a given pool size. Chunks are kept to an eighth of
  // the pool so that the table splits often and runs into the full case.
  task automatic random_phase(input logic [31:0] bytes, input int unsigned count,
                              input int unsigned pause_at);
    logic [31:0] chunk;
    write_pool(bytes);
    chunk = ((bytes >> 3) == 0) ? 32'd1 : (bytes >> 3);
    for (int unsigned n = 0; n < count; n++) begin
      if (n == pause_at) begin
        // The sender stops until the block has returned every result.
        in_valid = 1'b0;
        wait_drained();
      end
      send_item(make_request(chunk));
    end
  endtask

  // Result side. The receiver may stall before each result, except in one
  // stretch of 40 results out of every 120 where it always accepts at once.
  // Once, after the 150th result, it holds off while the sender keeps
  // offering, so the block fills and stalls its input.
  initial begin : take_results
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (results_seen == 150) gap = 300;
      else if (((results_seen / 40) % 3) == 1) gap = 0;
      else gap = $urandom_range(0, 5);
      if (gap != 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_item);
      results_seen++;
    end
  end

  initial begin
    sb           = new();
    items_sent   = 0;
    results_seen = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests on the reset pool of 16 MiB.
    send_alloc(32'd0);                              // zero size: ok at offset zero
    send_alloc(32'hFFFF_FFFF);                      // more than the free total
    send_alloc(32'd100);                            // split of the first segment
    send_alloc(32'd16777116);                       // exact fit of the remainder
    send_free(32'd100, 32'd16777116);               // plain free
    send_free(32'd100, 32'd1);                      // segment already free
    send_free(32'hFFFF_FFFF, 32'hFFFF_FFFF);        // no segment starts there
    send_free(32'd0, 32'hFFFF_FFFF);                // claimed size too large
    send_alloc(32'd16777200);                       // enough in total, no hole fits

    // Fill the table with fifteen splits on a 17-byte pool; the next split
    // is refused as table full, while an exact fit still succeeds.
    write_pool(32'd17);
    repeat (15) send_alloc(32'd1);
    send_alloc(32'd1);
    send_alloc(32'd2);

    // An empty pool refuses any nonzero size.
    write_pool(32'd0);
    send_alloc(32'd1);
    send_alloc(32'd0);

    random_phase(32'd256, 200, 100);
    random_phase(32'hFFFF_FFFF, 60, '1);
    random_phase(32'd1, 30, '1);
    random_phase(32'd4096, 110, '1);

    in_valid = 1'b0;
    wait_drained();
    repeat (64) @(posedge clk);
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
